// ===== hdl/mcp_pkg.sv =====
// mcp_pkg: shared types, character constants and codes for the motor command parser
// no dependencies; imported by every module of the block
package mcp_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // characters
    localparam logic [7:0] CH_ZERO     = 8'd48;
    localparam logic [7:0] CH_LBRACKET = 8'd91;
    localparam logic [7:0] CH_RBRACKET = 8'd93;
    localparam logic [7:0] CH_LBRACE   = 8'd123;
    localparam logic [7:0] CH_RBRACE   = 8'd125;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_COMMA    = 8'd44;
    localparam logic [7:0] CH_QUOTE    = 8'd39;
    localparam logic [7:0] CH_COLON    = 8'd58;

    // key letters
    localparam logic [7:0] KEY_NAME  = 8'd78;
    localparam logic [7:0] KEY_DIR   = 8'd68;
    localparam logic [7:0] KEY_SPEED = 8'd83;
    localparam logic [7:0] KEY_ROT   = 8'd82;

    // field codes
    localparam logic [1:0] CODE_DIR   = 2'd0;
    localparam logic [1:0] CODE_SPEED = 2'd1;
    localparam logic [1:0] CODE_ROT   = 2'd2;
    localparam logic [1:0] CODE_END   = 2'd3;

    // character classes set by the front end
    localparam logic [2:0] CLS_OTHER    = 3'd0;
    localparam logic [2:0] CLS_RBRACKET = 3'd1;
    localparam logic [2:0] CLS_SKIP     = 3'd2;
    localparam logic [2:0] CLS_QUOTE    = 3'd3;
    localparam logic [2:0] CLS_COLON    = 3'd4;
    localparam logic [2:0] CLS_TERM     = 3'd5;

    typedef struct packed {
        logic [2:0] cls;
        logic       name_match;
        logic [7:0] ch;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== hdl/motor_command_parser_core.sv =====
// motor_command_parser_core: top level of the motor command parser
// depends on mcp_pkg, mcp_front, mcp_queue and mcp_back
//
//   channel  handshake               payload
//   in       in_valid / in_stall     in_char
//   out      out_valid / out_stall   motor_select, field_code, field_value
//   cfg      cfg_valid / cfg_ready   cfg_data (first motor name character)
//
// one character per cycle sustained while in_stall is low; the back end updates its state on each pop
// a character is written into a queue entry, and its result is registered in the output stage when it is popped
// the two-entry queue lets the front keep taking characters while a result waits
// in_stall rises only when the queue is full; cfg_ready is always high
// rst_n clears parser state and queue; the name register returns to '0'
module motor_command_parser_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         in_char,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               motor_select,
    output logic [1:0]         field_code,
    output logic signed [31:0] field_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);
    import mcp_pkg::*;

    logic [7:0] name_reg;
    item_t      front_item;
    item_t      head_item;
    q_status_t  q_status;
    logic       push;
    logic       pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            name_reg <= CH_ZERO;
        else if (cfg_valid && cfg_ready)
            name_reg <= cfg_data;
    end

    assign in_stall = q_status.full;
    assign push     = in_valid && !in_stall;

    mcp_front u_front (
        .in_char   (in_char),
        .name_char (name_reg),
        .item      (front_item)
    );

    mcp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    mcp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (!q_status.empty),
        .head_item    (head_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .motor_select (motor_select),
        .field_code   (field_code),
        .field_value  (field_value)
    );

    // end of frame always carries the first motor and a zero value
    a_end_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && field_code == CODE_END) |-> (!motor_select && field_value == 32'sd0))
        else $error("end of frame result with non-zero payload");

    // single-character values stay within the character minus '0' range
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (field_code == CODE_DIR || field_code == CODE_SPEED))
            |-> (field_value >= -32'sd48 && field_value <= 32'sd207))
        else $error("direction or speed value out of range");

    // queue can never report full and empty together
    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");

    // an empty queue never pops
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> !pop)
        else $error("pop from empty queue");

endmodule

// ===== hdl/mcp_front.sv =====
// mcp_front: classifies each incoming character and compares it with the motor name
// depends on mcp_pkg
module mcp_front (
    input  logic [7:0]    in_char,
    input  logic [7:0]    name_char,
    output mcp_pkg::item_t item
);
    import mcp_pkg::*;

    logic [2:0] cls;

    always_comb
    begin
        case (in_char)
            CH_RBRACKET: cls = CLS_RBRACKET;
            CH_LBRACKET,
            CH_LBRACE,
            CH_SPACE:    cls = CLS_SKIP;
            CH_QUOTE:    cls = CLS_QUOTE;
            CH_COLON:    cls = CLS_COLON;
            CH_COMMA,
            CH_RBRACE:   cls = CLS_TERM;
            default:     cls = CLS_OTHER;
        endcase
    end

    assign item.cls        = cls;
    assign item.name_match = (in_char == name_char);
    assign item.ch         = in_char;

endmodule

// ===== hdl/mcp_queue.sv =====
// mcp_queue: short register queue between the classifying front and the executing back
// depends on mcp_pkg
module mcp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mcp_pkg::item_t        push_item,
    input  logic                  pop,
    output mcp_pkg::item_t        head_item,
    output mcp_pkg::q_status_t    status
);
    import mcp_pkg::*;

    item_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    assign head_item    = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ===== hdl/mcp_back.sv =====
// mcp_back: parser state, decimal accumulator and the registered result stage
// depends on mcp_pkg
module mcp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  mcp_pkg::item_t      head_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                motor_select,
    output logic [1:0]          field_code,
    output logic signed [31:0]  field_value
);
    import mcp_pkg::*;

    logic        key_open_reg,   key_open_next;
    logic        value_open_reg, value_open_next;
    logic [7:0]  key_letter_reg, key_letter_next;
    logic        motor_reg,      motor_next;
    logic        num_mode_reg,   num_mode_next;
    logic [31:0] acc_reg,        acc_next;

    logic        out_valid_reg,  out_valid_next;
    logic        out_motor_reg,  out_motor_next;
    logic [1:0]  out_code_reg,   out_code_next;
    logic [31:0] out_value_reg,  out_value_next;

    logic              emit;
    logic              emit_motor;
    logic [1:0]        emit_code;
    logic [31:0]       emit_value;
    logic signed [8:0] digit9;
    logic [31:0]       digit;

    // character minus '0', sign-extended
    assign digit9 = $signed({1'b0, head_item.ch}) - $signed({1'b0, CH_ZERO});
    assign digit  = {{23{digit9[8]}}, digit9};

    assign pop = head_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        key_open_next   = key_open_reg;
        value_open_next = value_open_reg;
        key_letter_next = key_letter_reg;
        motor_next      = motor_reg;
        num_mode_next   = num_mode_reg;
        acc_next        = acc_reg;
        emit            = 1'b0;
        emit_motor      = motor_reg;
        emit_code       = CODE_ROT;
        emit_value      = '0;

        if (num_mode_reg)
        begin
            if (head_item.cls == CLS_RBRACKET)
            begin
                // bracket inside a number closes it and the frame together
                emit            = 1'b1;
                emit_value      = acc_reg;
                key_open_next   = 1'b0;
                value_open_next = 1'b0;
                key_letter_next = '0;
                motor_next      = 1'b0;
                num_mode_next   = 1'b0;
                acc_next        = '0;
            end
            else if (head_item.cls == CLS_TERM)
            begin
                emit            = 1'b1;
                emit_value      = acc_reg;
                num_mode_next   = 1'b0;
                value_open_next = 1'b0;
                acc_next        = '0;
            end
            else
            begin
                acc_next = (acc_reg << 3) + (acc_reg << 1) + digit;
            end
        end
        else if (head_item.cls == CLS_RBRACKET)
        begin
            emit            = 1'b1;
            emit_motor      = 1'b0;
            emit_code       = CODE_END;
            key_open_next   = 1'b0;
            value_open_next = 1'b0;
            key_letter_next = '0;
            motor_next      = 1'b0;
            acc_next        = '0;
        end
        else if (head_item.cls == CLS_SKIP)
        begin
            emit = 1'b0;
        end
        else if (head_item.cls == CLS_QUOTE)
        begin
            key_open_next = !key_open_reg;
        end
        else if (key_open_reg)
        begin
            key_letter_next = head_item.ch;
        end
        else if (head_item.cls == CLS_COLON)
        begin
            value_open_next = !value_open_reg;
        end
        else if (value_open_reg)
        begin
            case (key_letter_reg)
                KEY_NAME:
                begin
                    motor_next      = !head_item.name_match;
                    value_open_next = 1'b0;
                end
                KEY_DIR:
                begin
                    emit            = 1'b1;
                    emit_code       = CODE_DIR;
                    emit_value      = digit;
                    value_open_next = 1'b0;
                end
                KEY_SPEED:
                begin
                    emit            = 1'b1;
                    emit_code       = CODE_SPEED;
                    emit_value      = digit;
                    value_open_next = 1'b0;
                end
                KEY_ROT:
                begin
                    if (head_item.cls == CLS_TERM)
                    begin
                        // empty rotation count
                        emit            = 1'b1;
                        value_open_next = 1'b0;
                    end
                    else
                    begin
                        acc_next      = digit;
                        num_mode_next = 1'b1;
                    end
                end
                default:
                begin
                    value_open_next = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        out_motor_next = out_motor_reg;
        out_code_next  = out_code_reg;
        out_value_next = out_value_reg;
        if (pop)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                out_motor_next = emit_motor;
                out_code_next  = emit_code;
                out_value_next = emit_value;
            end
        end
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_open_reg   <= 1'b0;
            value_open_reg <= 1'b0;
            key_letter_reg <= '0;
            motor_reg      <= 1'b0;
            num_mode_reg   <= 1'b0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                key_open_reg   <= key_open_next;
                value_open_reg <= value_open_next;
                key_letter_reg <= key_letter_next;
                motor_reg      <= motor_next;
                num_mode_reg   <= num_mode_next;
                acc_reg        <= acc_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_motor_reg <= out_motor_next;
        out_code_reg  <= out_code_next;
        out_value_reg <= out_value_next;
    end

    assign out_valid    = out_valid_reg;
    assign motor_select = out_motor_reg;
    assign field_code   = out_code_reg;
    assign field_value  = $signed(out_value_reg);

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for motor_command_parser_core
// drives character streams and name register writes, predicts every field write
// depends on mcp_pkg and the rtl of the parser
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mcp_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic        motor;
        logic [1:0]  code;
        logic [31:0] value;
    } field_write_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic [7:0]         in_char   = 8'd0;
    logic               out_stall = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [7:0]         cfg_data  = 8'd0;
    logic               in_stall;
    logic               out_valid;
    logic               motor_select;
    logic [1:0]         field_code;
    logic signed [31:0] field_value;
    logic               cfg_ready;

    // parser state as predicted
    logic        in_key     = 1'b0;
    logic        in_value   = 1'b0;
    logic [7:0]  last_key   = 8'd0;
    logic        sel_motor  = 1'b0;
    logic        in_number  = 1'b0;
    logic [31:0] rot_acc    = 32'd0;
    logic [7:0]  motor_name = CH_ZERO;

    logic [7:0]   char_backlog[$];
    field_write_t field_writes_due[$];
    field_write_t drv_write;
    field_write_t due_write;

    int  pushed_total  = 0;
    int  fail_cnt      = 0;
    int  quiet_cycles  = 0;
    int  in_gap        = 0;
    int  out_gap       = 0;
    int  hold_left     = 0;
    int  hold_asked    = 0;
    int  hold_served   = 0;
    bit  in_burst      = 1'b0;
    bit  in_idle_on    = 1'b1;
    bit  out_idle_on   = 1'b1;

    motor_command_parser_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_char      (in_char),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .motor_select (motor_select),
        .field_code   (field_code),
        .field_value  (field_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic void clear_parser();
        in_key    = 1'b0;
        in_value  = 1'b0;
        last_key  = 8'd0;
        sel_motor = 1'b0;
        in_number = 1'b0;
        rot_acc   = 32'd0;
    endfunction

    // advance the parser by one character; returns 1 when a field write results
    function automatic bit parse_char(input logic [7:0] c, output field_write_t fw);
        logic [31:0] digit;
        digit = {24'd0, c} - {24'd0, CH_ZERO};
        fw = '0;
        parse_char = 1'b0;
        if (in_number)
        begin
            if (c == CH_RBRACKET)
            begin
                fw = '{sel_motor, CODE_ROT, rot_acc};
                clear_parser();
                parse_char = 1'b1;
            end
            else if (c == CH_COMMA || c == CH_RBRACE)
            begin
                fw = '{sel_motor, CODE_ROT, rot_acc};
                rot_acc   = 32'd0;
                in_number = 1'b0;
                in_value  = 1'b0;
                parse_char = 1'b1;
            end
            else
            begin
                rot_acc = rot_acc * 32'd10 + digit;
            end
        end
        else if (c == CH_RBRACKET)
        begin
            clear_parser();
            fw = '{1'b0, CODE_END, 32'd0};
            parse_char = 1'b1;
        end
        else if (c == CH_LBRACKET || c == CH_LBRACE || c == CH_SPACE)
        begin
            // skipped outside a number
        end
        else if (c == CH_QUOTE)
            in_key = ~in_key;
        else if (in_key)
            last_key = c;
        else if (c == CH_COLON)
            in_value = ~in_value;
        else if (in_value)
        begin
            in_value = 1'b0;
            case (last_key)
                KEY_NAME:  sel_motor = (c != motor_name);
                KEY_DIR:
                begin
                    fw = '{sel_motor, CODE_DIR, digit};
                    parse_char = 1'b1;
                end
                KEY_SPEED:
                begin
                    fw = '{sel_motor, CODE_SPEED, digit};
                    parse_char = 1'b1;
                end
                KEY_ROT:
                begin
                    if (c == CH_COMMA || c == CH_RBRACE)
                    begin
                        fw = '{sel_motor, CODE_ROT, 32'd0};
                        parse_char = 1'b1;
                    end
                    else
                    begin
                        rot_acc   = digit;
                        in_number = 1'b1;
                        in_value  = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap(input bit on);
        int r;
        r = $urandom_range(0, 99);
        if (!on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t ns: %s", $realtime, msg);
    endtask

    // character driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (parse_char(in_char, drv_write))
                    field_writes_due.push_back(drv_write);
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0 && !in_burst)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (char_backlog.size() > 0)
                begin
                    in_char  <= char_backlog.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 63) == 0)
                        in_idle_on = ($urandom_range(0, 3) != 0);
                    in_gap = in_burst ? 0 : pick_gap(in_idle_on);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (field_writes_due.size() == 0)
                begin
                    note_failure($sformatf("unexpected transaction: motor %0d code %0d value %0d",
                                           motor_select, field_code, field_value));
                end
                else
                begin
                    due_write = field_writes_due.pop_front();
                    if (motor_select !== due_write.motor || field_code !== due_write.code ||
                        field_value !== due_write.value)
                        note_failure($sformatf({"mismatch: expected motor %0d code %0d value %0d",
                                                ", got motor %0d code %0d value %0d"},
                                               due_write.motor, due_write.code,
                                               $signed(due_write.value), motor_select,
                                               field_code, field_value));
                end
            end
            if ($urandom_range(0, 99) == 0)
                out_idle_on = ($urandom_range(0, 3) != 0);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_asked != hold_served)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                out_gap = pick_gap(out_idle_on);
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic push_char(input logic [7:0] c);
        char_backlog.push_back(c);
        pushed_total++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    task automatic push_key(input logic [7:0] k);
        push_char(CH_QUOTE);
        push_char(k);
        push_char(CH_QUOTE);
        push_char(CH_COLON);
    endtask

    task automatic push_digit_or_byte(input int byte_pct);
        if ($urandom_range(0, 99) < byte_pct)
            push_char(8'($urandom_range(0, 255)));
        else
            push_char(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic push_record();
        int n_keys;
        int n_digits;
        int r;
        push_char(CH_LBRACE);
        n_keys = $urandom_range(1, 5);
        for (int k = 0; k < n_keys; k++)
        begin
            if (k > 0)
                push_text(", ");
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    push_key(KEY_NAME);
                    r = $urandom_range(0, 3);
                    if (r == 0)
                        push_char(motor_name);
                    else if (r == 1)
                        push_char(motor_name ^ 8'h01);
                    else
                        push_digit_or_byte(30);
                end
                2, 3:
                begin
                    push_key(KEY_DIR);
                    push_digit_or_byte(20);
                end
                4, 5:
                begin
                    push_key(KEY_SPEED);
                    push_digit_or_byte(20);
                end
                6, 7, 8:
                begin
                    push_key(KEY_ROT);
                    // empty, short or overflowing numbers
                    r = $urandom_range(0, 7);
                    n_digits = (r == 0) ? 0 : (r == 1) ? $urandom_range(10, 12)
                                                     : $urandom_range(1, 4);
                    for (int d = 0; d < n_digits; d++)
                        push_digit_or_byte(10);
                    r = $urandom_range(0, 99);
                    push_char(r < 70 ? CH_COMMA : r < 90 ? CH_RBRACE : CH_RBRACKET);
                end
                default:
                begin
                    push_key(8'($urandom_range(0, 255)));
                    push_char(8'($urandom_range(0, 255)));
                end
            endcase
        end
        push_char(CH_RBRACE);
    endtask

    task automatic push_frames(input int target);
        int first;
        int n_recs;
        int r;
        first = pushed_total;
        while (pushed_total - first < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                repeat ($urandom_range(1, 8))
                    push_char(8'($urandom_range(0, 255)));
            end
            else if (r < 20)
            begin
                // broken framing: stray quote or colon
                push_char(($urandom_range(0, 1) != 0) ? CH_QUOTE : CH_COLON);
            end
            push_char(CH_LBRACKET);
            n_recs = $urandom_range(1, 3);
            for (int i = 0; i < n_recs; i++)
            begin
                if (i > 0)
                    push_text(";");
                push_record();
            end
            if ($urandom_range(0, 9) != 0)
                push_char(CH_RBRACKET);
        end
    endtask

    // sender waits for every outstanding result, then for the pipeline to drain
    task automatic wait_idle();
        do
            @(negedge clk);
        while (char_backlog.size() != 0 || in_valid || field_writes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_name(input logic [7:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        motor_name = v;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        // release away from the active edge
        @(negedge clk);
        rst_n = 1'b1;

        // extremes, skipped characters, empty rotation, unknown key,
        // bracket inside a number, colon toggling and end of frame
        push_text("[{'N':0 'D':");
        push_char(8'hFF);
        push_text("'S':");
        push_char(8'h00);
        push_text("'R':,'Q':7'R':9]::]");
        wait_idle();

        write_name(8'h00);
        push_frames(250);
        wait_idle();

        write_name(8'hFF);
        push_frames(250);
        wait_idle();

        // receiver holds off while the sender keeps offering direction writes
        write_name(CH_ZERO + 8'd5);
        @(negedge clk);
        in_burst = 1'b1;
        hold_asked++;
        repeat (60)
        begin
            push_key(KEY_DIR);
            push_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        wait_idle();
        in_burst = 1'b0;
        push_frames(125);
        wait_idle();

        write_name(8'($urandom_range(0, 255)));
        push_frames(250);
        wait_idle();

        write_name(CH_ZERO);
        push_frames(125);
        wait_idle();

        repeat (16) @(posedge clk);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== motor_command_parser_core.f =====
hdl/mcp_pkg.sv
hdl/mcp_front.sv
hdl/mcp_queue.sv
hdl/mcp_back.sv
hdl/motor_command_parser_core.sv
verif/tb_top.sv
